// File: rtl/qalu_pkg.sv
// Shared types and constants for the quaternion ALU.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package qalu_pkg;

    // Number format
    localparam int FRAC_BITS    = 12;
    localparam int COMP_WIDTH   = 16;
    localparam int CMD_WIDTH    = 3;
    localparam int STATUS_WIDTH = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Datapath widths
    localparam int PROD_W = 2 * COMP_WIDTH;          // raw component product
    localparam int RND_W  = PROD_W - FRAC_BITS;      // product after rounding
    localparam int SUM_W  = RND_W + 3;               // sum of four rounded products
    localparam int SQ_W   = PROD_W - 1;              // square of a magnitude
    localparam int M2_W   = SQ_W + 2;                // sum of four squares
    localparam int ROOT_W = 32;                      // integer square root
    localparam int NV_W   = 2 * ROOT_W;              // normalized magnitude word
    localparam int REM_W  = ROOT_W + 3;              // square root remainder
    localparam int K_W    = 5;                       // half of the normalize shift

    // Normalize pipeline depth
    localparam int SHIFT_STAGES = 5;                 // even shifts 32,16,8,4,2
    localparam int SQ_STEPS     = ROOT_W;            // one root bit per stage
    localparam int DIV_STEPS    = COMP_WIDTH;        // one quotient bit per stage
    localparam int NORM_LAT     = SHIFT_STAGES + SQ_STEPS + 1 + DIV_STEPS;

    // Command codes on the input channel
    localparam logic [CMD_WIDTH-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_HAM   = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_SCALE = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_NORM  = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_EQ    = 3'd5;

    typedef logic [COMP_WIDTH-1:0] comp_t;

    // Decoded operation class
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_HAM   = 3'd2,
        OP_SCALE = 3'd3,
        OP_NORM  = 3'd4,
        OP_EQ    = 3'd5,
        OP_NONE  = 3'd6
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // One classified operation, index 0..3 is x, y, z, w
    typedef struct packed {
        op_t         op;
        comp_t [3:0] a;
        comp_t [3:0] b;
        comp_t       s;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/qalu_front.sv
// Input stage of the quaternion ALU: takes transfers and decodes the command.
// Depends on qalu_pkg; feeds qalu_fifo.
`default_nettype none

module qalu_front import qalu_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [CMD_WIDTH-1:0]         s_command,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_x,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_y,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_z,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_w,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_x,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_y,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_z,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_w,
    input  wire logic signed [COMP_WIDTH-1:0] s_scale_factor,
    output logic                              push,
    output item_t                             push_item,
    input  wire logic                         queue_full
);

    logic  hold_valid_reg, hold_valid_next;
    item_t hold_item_reg;
    item_t item_next;
    logic  take;

    // Holding register frees whenever the queue has room
    assign push    = hold_valid_reg && !queue_full;
    assign s_ready = !hold_valid_reg || !queue_full;
    assign take    = s_valid && s_ready;

    // Command decode
    always_comb begin
        item_next.a = {s_a_w, s_a_z, s_a_y, s_a_x};
        item_next.b = {s_b_w, s_b_z, s_b_y, s_b_x};
        item_next.s = s_scale_factor;
        case (s_command)
            CMD_ADD:   item_next.op = OP_ADD;
            CMD_SUB:   item_next.op = OP_SUB;
            CMD_HAM:   item_next.op = OP_HAM;
            CMD_SCALE: item_next.op = OP_SCALE;
            CMD_NORM:  item_next.op = OP_NORM;
            CMD_EQ:    item_next.op = OP_EQ;
            default:   item_next.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (take) begin
            hold_valid_next = 1'b1;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hold_item_reg <= item_next;
        end
    end

    assign push_item = hold_item_reg;

endmodule

`default_nettype wire

// File: rtl/qalu_fifo.sv
// Short queue of decoded operations between the front and back stages.
// Depends on qalu_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module qalu_fifo import qalu_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output item_t      pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qalu_norm.sv
// Normalize datapath: even normalizing shift, pipelined square root and
// four pipelined restoring dividers. Depends on qalu_pkg; used by qalu_back.
`default_nettype none

module qalu_norm import qalu_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [M2_W-1:0]   m2,
    input  wire comp_t [3:0]       mag,
    output comp_t [3:0]            quo
);

    // Shift stages
    logic [NV_W-1:0]   sh_v_reg   [SHIFT_STAGES];
    logic [K_W-1:0]    sh_k_reg   [SHIFT_STAGES];
    comp_t [3:0]       sh_mag_reg [SHIFT_STAGES];
    logic [NV_W-1:0]   sh_v_next  [SHIFT_STAGES];
    logic [K_W-1:0]    sh_k_next  [SHIFT_STAGES];

    // Square root stages
    logic [REM_W-1:0]  sq_rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] sq_root_reg [SQ_STEPS];
    logic [NV_W-1:0]   sq_v_reg    [SQ_STEPS];
    logic [K_W-1:0]    sq_k_reg    [SQ_STEPS];
    comp_t [3:0]       sq_mag_reg  [SQ_STEPS];
    logic [REM_W-1:0]  sq_rem_next  [SQ_STEPS];
    logic [ROOT_W-1:0] sq_root_next [SQ_STEPS];

    // Dividend setup stage
    logic [ROOT_W-1:0]    nm_rem_reg [4];
    logic [DIV_STEPS-1:0] nm_low_reg [4];
    logic [ROOT_W-1:0]    nm_root_reg;
    logic [ROOT_W-1:0]    nm_rem_next [4];
    logic [DIV_STEPS-1:0] nm_low_next [4];

    // Divider stages
    logic [ROOT_W-1:0]    dv_rem_reg  [DIV_STEPS][4];
    logic [DIV_STEPS-1:0] dv_low_reg  [DIV_STEPS][4];
    comp_t                dv_quo_reg  [DIV_STEPS][4];
    logic [ROOT_W-1:0]    dv_root_reg [DIV_STEPS];
    logic [ROOT_W-1:0]    dv_rem_next [DIV_STEPS][4];
    comp_t                dv_quo_next [DIV_STEPS][4];

    // Even left shift: largest shift that keeps the value in NV_W bits
    always_comb begin
        logic [NV_W-1:0] v_in;
        logic [K_W-1:0]  k_in;
        int              sh;
        for (int g = 0; g < SHIFT_STAGES; g++) begin
            sh   = 1 << (SHIFT_STAGES - g);
            v_in = (g == 0) ? NV_W'(m2) : sh_v_reg[g-1];
            k_in = (g == 0) ? '0 : sh_k_reg[g-1];
            if ((v_in >> (NV_W - sh)) == '0) begin
                sh_v_next[g] = v_in << sh;
                sh_k_next[g] = k_in + K_W'(sh / 2);
            end else begin
                sh_v_next[g] = v_in;
                sh_k_next[g] = k_in;
            end
        end
    end

    // Digit-by-digit square root, two radicand bits per stage
    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [NV_W-1:0]   v_in;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  tgt;
        for (int s = 0; s < SQ_STEPS; s++) begin
            rem_in  = (s == 0) ? '0 : sq_rem_reg[s-1];
            root_in = (s == 0) ? '0 : sq_root_reg[s-1];
            v_in    = (s == 0) ? sh_v_reg[SHIFT_STAGES-1] : sq_v_reg[s-1];
            trial   = {rem_in[REM_W-3:0], v_in[2*(SQ_STEPS-1-s) +: 2]};
            tgt     = REM_W'({root_in, 2'b01});
            if (trial >= tgt) begin
                sq_rem_next[s]  = trial - tgt;
                sq_root_next[s] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_next[s]  = trial;
                sq_root_next[s] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Dividend: magnitude scaled by 2^(FRAC_BITS+k) plus half the divisor
    always_comb begin
        logic [NV_W-1:0] num;
        for (int i = 0; i < 4; i++) begin
            num = (NV_W'(sq_mag_reg[SQ_STEPS-1][i]) << (FRAC_BITS + int'(sq_k_reg[SQ_STEPS-1])))
                + NV_W'(sq_root_reg[SQ_STEPS-1] >> 1);
            nm_rem_next[i] = num[ROOT_W+DIV_STEPS-1:DIV_STEPS];
            nm_low_next[i] = num[DIV_STEPS-1:0];
        end
    end

    // Restoring division, one quotient bit per stage
    always_comb begin
        logic [ROOT_W-1:0]    rem_in;
        logic [DIV_STEPS-1:0] low_in;
        comp_t                quo_in;
        logic [ROOT_W-1:0]    den;
        logic [ROOT_W:0]      trial;
        for (int d = 0; d < DIV_STEPS; d++) begin
            den = (d == 0) ? nm_root_reg : dv_root_reg[d-1];
            for (int i = 0; i < 4; i++) begin
                rem_in = (d == 0) ? nm_rem_reg[i] : dv_rem_reg[d-1][i];
                low_in = (d == 0) ? nm_low_reg[i] : dv_low_reg[d-1][i];
                quo_in = (d == 0) ? '0 : dv_quo_reg[d-1][i];
                trial  = {rem_in, low_in[DIV_STEPS-1-d]};
                if (trial >= {1'b0, den}) begin
                    dv_rem_next[d][i] = ROOT_W'(trial - {1'b0, den});
                    dv_quo_next[d][i] = {quo_in[COMP_WIDTH-2:0], 1'b1};
                end else begin
                    dv_rem_next[d][i] = trial[ROOT_W-1:0];
                    dv_quo_next[d][i] = {quo_in[COMP_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    // Pipeline registers, all held while the back end stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < SHIFT_STAGES; g++) begin
                sh_v_reg[g]   <= sh_v_next[g];
                sh_k_reg[g]   <= sh_k_next[g];
                sh_mag_reg[g] <= (g == 0) ? mag : sh_mag_reg[g-1];
            end
            for (int s = 0; s < SQ_STEPS; s++) begin
                sq_rem_reg[s]  <= sq_rem_next[s];
                sq_root_reg[s] <= sq_root_next[s];
                sq_v_reg[s]    <= (s == 0) ? sh_v_reg[SHIFT_STAGES-1] : sq_v_reg[s-1];
                sq_k_reg[s]    <= (s == 0) ? sh_k_reg[SHIFT_STAGES-1] : sq_k_reg[s-1];
                sq_mag_reg[s]  <= (s == 0) ? sh_mag_reg[SHIFT_STAGES-1] : sq_mag_reg[s-1];
            end
            nm_root_reg <= sq_root_reg[SQ_STEPS-1];
            for (int i = 0; i < 4; i++) begin
                nm_rem_reg[i] <= nm_rem_next[i];
                nm_low_reg[i] <= nm_low_next[i];
            end
            for (int d = 0; d < DIV_STEPS; d++) begin
                dv_root_reg[d] <= (d == 0) ? nm_root_reg : dv_root_reg[d-1];
                for (int i = 0; i < 4; i++) begin
                    dv_rem_reg[d][i] <= dv_rem_next[d][i];
                    dv_low_reg[d][i] <= (d == 0) ? nm_low_reg[i] : dv_low_reg[d-1][i];
                    dv_quo_reg[d][i] <= dv_quo_next[d][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quo[i] = dv_quo_reg[DIV_STEPS-1][i];
        end
    end

endmodule

`default_nettype wire

// File: rtl/qalu_back.sv
// Execution pipeline: products, sums, saturation, normalize and output register.
// Depends on qalu_pkg and qalu_norm; pops operations from qalu_fifo.
`default_nettype none

module qalu_back import qalu_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire item_t                 q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [COMP_WIDTH-1:0] m_r_x,
    output logic signed [COMP_WIDTH-1:0] m_r_y,
    output logic signed [COMP_WIDTH-1:0] m_r_z,
    output logic signed [COMP_WIDTH-1:0] m_r_w,
    output logic                       m_are_equal,
    output logic [STATUS_WIDTH-1:0]    m_status
);

    typedef struct packed {
        logic  flag;
        comp_t val;
    } sat_t;

    // Result of the early stages, carried alongside the normalize pipeline
    typedef struct packed {
        op_t         op;
        comp_t [3:0] r;
        logic        eq;
        status_t     status;
        logic [3:0]  neg;
        logic        zero;
    } side_t;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COMP_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1 << (FRAC_BITS - 1));

    function automatic sat_t sat_comp(input logic signed [SUM_W-1:0] v);
        sat_t res;
        if (v > SAT_HI) begin
            res.flag = 1'b1;
            res.val  = SAT_HI[COMP_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            res.flag = 1'b1;
            res.val  = SAT_LO[COMP_WIDTH-1:0];
        end else begin
            res.flag = 1'b0;
            res.val  = v[COMP_WIDTH-1:0];
        end
        return res;
    endfunction

    logic adv;

    // Stage A: operation from the queue
    logic  a_valid_reg;
    item_t a_item_reg;

    // Stage B: raw products
    logic                     b_valid_reg;
    op_t                      b_op_reg;
    comp_t [3:0]              b_a_reg;
    comp_t [3:0]              b_b_reg;
    logic signed [PROD_W-1:0] b_prod_reg  [4][4];
    logic signed [PROD_W-1:0] b_prod_next [4][4];

    // Stage C: rounded products and squares
    logic                    c_valid_reg;
    op_t                     c_op_reg;
    comp_t [3:0]             c_a_reg;
    comp_t [3:0]             c_b_reg;
    logic signed [RND_W-1:0] c_rnd_reg  [4][4];
    logic [SQ_W-1:0]         c_sq_reg   [4];
    logic signed [RND_W-1:0] c_rnd_next [4][4];

    // Stage D: early result and normalize inputs
    logic            d_valid_reg;
    side_t           d_side_reg, d_side_next;
    logic [M2_W-1:0] d_m2_reg, d_m2_next;
    comp_t [3:0]     d_mag_reg, d_mag_next;

    // Delay line matching the normalize pipeline
    logic  sd_valid_reg [NORM_LAT];
    side_t sd_side_reg  [NORM_LAT];

    comp_t [3:0] nm_quo;

    // Output register
    logic                      out_valid_reg;
    comp_t [3:0]               out_r_reg, out_r_next;
    logic                      out_eq_reg, out_eq_next;
    status_t                   out_status_reg, out_status_next;

    // Whole pipeline moves unless a result waits at the output
    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = q_valid && adv;

    // Multiplier operands chosen by operation
    always_comb begin
        comp_t bop;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                case (a_item_reg.op)
                    OP_SCALE: bop = a_item_reg.s;
                    OP_NORM:  bop = a_item_reg.a[j];
                    default:  bop = a_item_reg.b[j];
                endcase
                b_prod_next[i][j] = $signed(a_item_reg.a[i]) * $signed(bop);
            end
        end
    end

    // Round to nearest, ties away from zero
    always_comb begin
        logic signed [PROD_W-1:0] t;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                t = b_prod_reg[i][j] + (b_prod_reg[i][j][PROD_W-1] ? HALF - 1'b1 : HALF);
                c_rnd_next[i][j] = RND_W'(t >>> FRAC_BITS);
            end
        end
    end

    // Sums, saturation, compare and normalize setup
    always_comb begin
        logic signed [SUM_W-1:0] pe [4][4];
        logic signed [SUM_W-1:0] sv [4];
        sat_t                    st;
        logic                    any_sat;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pe[i][j] = SUM_W'(c_rnd_reg[i][j]);
            end
        end
        for (int i = 0; i < 4; i++) begin
            sv[i] = '0;
        end
        case (c_op_reg)
            OP_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    sv[i] = SUM_W'($signed(c_a_reg[i])) + SUM_W'($signed(c_b_reg[i]));
                end
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    sv[i] = SUM_W'($signed(c_a_reg[i])) - SUM_W'($signed(c_b_reg[i]));
                end
            end
            OP_HAM: begin
                sv[0] = pe[0][3] + pe[3][0] + pe[1][2] - pe[2][1];
                sv[1] = pe[1][3] + pe[3][1] + pe[2][0] - pe[0][2];
                sv[2] = pe[2][3] + pe[3][2] + pe[0][1] - pe[1][0];
                sv[3] = pe[3][3] - pe[0][0] - pe[1][1] - pe[2][2];
            end
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    sv[i] = pe[i][i];
                end
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    sv[i] = '0;
                end
            end
        endcase
        any_sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            st = sat_comp(sv[i]);
            d_side_next.r[i]   = st.val;
            any_sat            = any_sat | st.flag;
            d_side_next.neg[i] = c_a_reg[i][COMP_WIDTH-1];
            d_mag_next[i]      = c_a_reg[i][COMP_WIDTH-1] ? -c_a_reg[i] : c_a_reg[i];
        end
        d_side_next.op     = c_op_reg;
        d_side_next.eq     = (c_op_reg == OP_EQ) && (c_a_reg == c_b_reg);
        d_side_next.status = any_sat ? ST_SAT : ST_OK;
        d_m2_next = M2_W'(c_sq_reg[0]) + M2_W'(c_sq_reg[1])
                  + M2_W'(c_sq_reg[2]) + M2_W'(c_sq_reg[3]);
        d_side_next.zero = (d_m2_next == '0);
    end

    qalu_norm u_norm (
        .aclk (aclk),
        .en   (adv),
        .m2   (d_m2_reg),
        .mag  (d_mag_reg),
        .quo  (nm_quo)
    );

    // Final selection: normalize quotients or early result
    always_comb begin
        side_t                   sd;
        logic signed [SUM_W-1:0] qv;
        sat_t                    st;
        logic                    any_sat;
        qv      = '0;
        st      = '0;
        any_sat = 1'b0;
        sd = sd_side_reg[NORM_LAT-1];
        out_r_next      = sd.r;
        out_eq_next     = sd.eq;
        out_status_next = sd.status;
        if (sd.op == OP_NORM) begin
            out_eq_next = 1'b0;
            if (sd.zero) begin
                out_r_next      = '0;
                out_status_next = ST_ZERO;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    qv = SUM_W'(nm_quo[i]);
                    st = sat_comp(sd.neg[i] ? -qv : qv);
                    out_r_next[i] = st.val;
                    any_sat       = any_sat | st.flag;
                end
                out_status_next = any_sat ? ST_SAT : ST_OK;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NORM_LAT; n++) begin
                sd_valid_reg[n] <= 1'b0;
            end
        end else if (adv) begin
            a_valid_reg   <= q_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= sd_valid_reg[NORM_LAT-1];
            for (int n = 0; n < NORM_LAT; n++) begin
                sd_valid_reg[n] <= (n == 0) ? d_valid_reg : sd_valid_reg[n-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_item_reg <= q_item;
            b_op_reg   <= a_item_reg.op;
            b_a_reg    <= a_item_reg.a;
            b_b_reg    <= a_item_reg.b;
            c_op_reg   <= b_op_reg;
            c_a_reg    <= b_a_reg;
            c_b_reg    <= b_b_reg;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    b_prod_reg[i][j] <= b_prod_next[i][j];
                    c_rnd_reg[i][j]  <= c_rnd_next[i][j];
                end
                c_sq_reg[i] <= b_prod_reg[i][i][SQ_W-1:0];
            end
            d_side_reg <= d_side_next;
            d_m2_reg   <= d_m2_next;
            d_mag_reg  <= d_mag_next;
            for (int n = 0; n < NORM_LAT; n++) begin
                sd_side_reg[n] <= (n == 0) ? d_side_reg : sd_side_reg[n-1];
            end
            out_r_reg      <= out_r_next;
            out_eq_reg     <= out_eq_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_r_x       = $signed(out_r_reg[0]);
    assign m_r_y       = $signed(out_r_reg[1]);
    assign m_r_z       = $signed(out_r_reg[2]);
    assign m_r_w       = $signed(out_r_reg[3]);
    assign m_are_equal = out_eq_reg;
    assign m_status    = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/quaternion_alu_unit.sv
// Top level of the quaternion ALU: front stage, operation queue, back pipeline.
// Depends on qalu_pkg, qalu_front, qalu_fifo, qalu_back (and qalu_norm below it).
//
//   channel   dir  ports                                        transfer when
//   input     in   s_command, s_a_*, s_b_*, s_scale_factor      s_valid && s_ready
//   result    out  m_r_x/y/z/w, m_are_equal, m_status           m_valid && m_ready
//
// One operation enters and one result leaves per clock while m_ready stays high.
// Every command takes the same path: front register, queue, four arithmetic
// stages, then 54 stages of normalize (even shift, 32-stage square root, dividend
// setup, 16-stage divider) which all commands pass through to keep order.
// Synchronous active-low reset empties the queue and all pipeline valid bits.
// A stalled result freezes the back pipeline; queue and front fill up, then stall.
`default_nettype none

module quaternion_alu_unit import qalu_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [CMD_WIDTH-1:0]         s_command,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_x,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_y,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_z,
    input  wire logic signed [COMP_WIDTH-1:0] s_a_w,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_x,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_y,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_z,
    input  wire logic signed [COMP_WIDTH-1:0] s_b_w,
    input  wire logic signed [COMP_WIDTH-1:0] s_scale_factor,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COMP_WIDTH-1:0]      m_r_x,
    output logic signed [COMP_WIDTH-1:0]      m_r_y,
    output logic signed [COMP_WIDTH-1:0]      m_r_z,
    output logic signed [COMP_WIDTH-1:0]      m_r_w,
    output logic                              m_are_equal,
    output logic [STATUS_WIDTH-1:0]           m_status
);

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  pop_valid;
    item_t pop_item;

    qalu_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_a_x          (s_a_x),
        .s_a_y          (s_a_y),
        .s_a_z          (s_a_z),
        .s_a_w          (s_a_w),
        .s_b_x          (s_b_x),
        .s_b_y          (s_b_y),
        .s_b_z          (s_b_z),
        .s_b_w          (s_b_w),
        .s_scale_factor (s_scale_factor),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    qalu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    qalu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_item      (pop_item),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_r_x       (m_r_x),
        .m_r_y       (m_r_y),
        .m_r_z       (m_r_z),
        .m_r_w       (m_r_w),
        .m_are_equal (m_are_equal),
        .m_status    (m_status)
    );

endmodule

`default_nettype wire
